FILE: src/pbacp_pkg.sv
// Package for the paged bump allocator / compaction planner.
// Holds command and status codes, register defaults and the result word type.
// No dependencies.
package pbacp_pkg;

    localparam int MAX_PAGES_DEF = 256;

    localparam int SIZE_W = 32;
    localparam int CFG_W  = 17;
    localparam int OFF_W  = 17;

    // round-up amount for 8-byte granules
    localparam logic [32:0] GRANULE_ROUND = 33'd7;

    localparam logic [CFG_W-1:0] PAGE_BYTES_RST = 17'd4096;
    localparam logic [CFG_W-1:0] LARGE_THR_RST  = 17'd1024;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_BEGIN = 2'd1,
        CMD_PLAN  = 2'd2,
        CMD_END   = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PAGE  = 2'd1;
    localparam logic [1:0] ST_BAD_MODE = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_PAGE_BYTES = 1'b0;
    localparam logic REG_LARGE_THR  = 1'b1;

    typedef struct packed {
        logic [8:0]  pages_freed;
        logic [8:0]  pages_in_use;
        logic [1:0]  status;
        logic        freed;
        logic        is_large;
        logic [15:0] offset;
        logic [7:0]  page;
    } t_result;

endpackage

FILE: src/paged_bump_allocator_compaction_planner.sv
// Top level of the paged bump allocator with compaction planner.
// Holds config registers, placement state and the result register; uses
// pbacp_pkg and pbacp_step.
//
// Every command word yields exactly one result word. A command's result is
// registered in the output register in the cycle after it is taken; a new
// command is taken each cycle as long as the output register is empty or is
// being drained, so sustained rate is one word per clock. The only loop is the
// placement state register fed back through one round-up, add and compare.
// Configuration (page_bytes at 0x0, large_threshold at 0x4) should be written
// only while no command is in flight.
module paged_bump_allocator_compaction_planner #(
    parameter int MAX_PAGES = pbacp_pkg::MAX_PAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // object_size[31:0], keep[32], zero pad [39:33]
    input  logic [1:0]  s_tuser,   // command[1:0]
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    // page[7:0], offset[23:8], is_large[24], freed[25], status[27:26],
    // pages_in_use[36:28], pages_freed[45:37], zero pad [47:46]
    output logic [47:0] m_tdata,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TW = $clog2(MAX_PAGES + 1);
    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    logic [pbacp_pkg::CFG_W-1:0] r_page_bytes;
    logic [pbacp_pkg::CFG_W-1:0] r_large_thr;
    logic [TW-1:0]               r_page_total;
    logic [PW-1:0]               r_alloc_page;
    logic [pbacp_pkg::OFF_W-1:0] r_alloc_off;
    logic [PW-1:0]               r_reloc_page;
    logic [pbacp_pkg::OFF_W-1:0] r_reloc_off;
    logic                        r_compacting;
    logic                        r_out_valid;
    pbacp_pkg::t_result          r_out;

    logic [TW-1:0]               n_page_total;
    logic [PW-1:0]               n_alloc_page;
    logic [pbacp_pkg::OFF_W-1:0] n_alloc_off;
    logic [PW-1:0]               n_reloc_page;
    logic [pbacp_pkg::OFF_W-1:0] n_reloc_off;
    logic                        n_compacting;
    pbacp_pkg::t_result          n_out;

    logic accept;
    logic cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign s_tready = !r_out_valid || m_tready;
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_out};

    always_comb begin
        if (paddr[2] == pbacp_pkg::REG_LARGE_THR) begin
            prdata = 32'(r_large_thr);
        end else begin
            prdata = 32'(r_page_bytes);
        end
    end

    pbacp_step #(
        .MAX_PAGES (MAX_PAGES),
        .TW        (TW),
        .PW        (PW)
    ) u_step (
        .i_cmd        (s_tuser),
        .i_size       (s_tdata[31:0]),
        .i_keep       (s_tdata[32]),
        .i_page_bytes (r_page_bytes),
        .i_large_thr  (r_large_thr),
        .i_page_total (r_page_total),
        .i_alloc_page (r_alloc_page),
        .i_alloc_off  (r_alloc_off),
        .i_reloc_page (r_reloc_page),
        .i_reloc_off  (r_reloc_off),
        .i_compacting (r_compacting),
        .o_page_total (n_page_total),
        .o_alloc_page (n_alloc_page),
        .o_alloc_off  (n_alloc_off),
        .o_reloc_page (n_reloc_page),
        .o_reloc_off  (n_reloc_off),
        .o_compacting (n_compacting),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_bytes <= pbacp_pkg::PAGE_BYTES_RST;
            r_large_thr  <= pbacp_pkg::LARGE_THR_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == pbacp_pkg::REG_LARGE_THR) begin
                r_large_thr <= pwdata[pbacp_pkg::CFG_W-1:0];
            end else begin
                r_page_bytes <= pwdata[pbacp_pkg::CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_total <= '0;
            r_alloc_page <= '0;
            r_alloc_off  <= '0;
            r_reloc_page <= '0;
            r_reloc_off  <= '0;
            r_compacting <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_page_total <= n_page_total;
                r_alloc_page <= n_alloc_page;
                r_alloc_off  <= n_alloc_off;
                r_reloc_page <= n_reloc_page;
                r_reloc_off  <= n_reloc_off;
                r_compacting <= n_compacting;
                r_out_valid  <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: src/pbacp_step.sv
// Combinational step of the allocator: next placement state and result word
// for one command. Depends on pbacp_pkg.
module pbacp_step #(
    parameter int MAX_PAGES = pbacp_pkg::MAX_PAGES_DEF,
    parameter int TW = $clog2(MAX_PAGES + 1),
    parameter int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
    input  logic [1:0]                   i_cmd,
    input  logic [pbacp_pkg::SIZE_W-1:0] i_size,
    input  logic                         i_keep,
    input  logic [pbacp_pkg::CFG_W-1:0]  i_page_bytes,
    input  logic [pbacp_pkg::CFG_W-1:0]  i_large_thr,
    input  logic [TW-1:0]                i_page_total,
    input  logic [PW-1:0]                i_alloc_page,
    input  logic [pbacp_pkg::OFF_W-1:0]  i_alloc_off,
    input  logic [PW-1:0]                i_reloc_page,
    input  logic [pbacp_pkg::OFF_W-1:0]  i_reloc_off,
    input  logic                         i_compacting,
    output logic [TW-1:0]                o_page_total,
    output logic [PW-1:0]                o_alloc_page,
    output logic [pbacp_pkg::OFF_W-1:0]  o_alloc_off,
    output logic [PW-1:0]                o_reloc_page,
    output logic [pbacp_pkg::OFF_W-1:0]  o_reloc_off,
    output logic                         o_compacting,
    output pbacp_pkg::t_result           o_result
);

    localparam int CW = TW + 1;

    logic [32:0]                  aligned;
    logic [pbacp_pkg::OFF_W-1:0]  al_lo;
    logic                         fits;
    logic [pbacp_pkg::OFF_W:0]    a_sum;
    logic [pbacp_pkg::OFF_W:0]    r_sum;
    logic                         a_over;
    logic                         r_over;
    logic                         full;
    logic [CW-1:0]                reloc_next;
    logic [CW-1:0]                total_ext;
    logic [31:0]                  page_wide;
    logic [31:0]                  total_wide;
    logic [31:0]                  drop_wide;
    logic [TW-1:0]                dropped;

    always_comb begin
        aligned    = ({1'b0, i_size} + pbacp_pkg::GRANULE_ROUND) & ~pbacp_pkg::GRANULE_ROUND;
        al_lo      = aligned[pbacp_pkg::OFF_W-1:0];
        fits       = aligned <= 33'(i_page_bytes);
        a_sum      = {1'b0, i_alloc_off} + {1'b0, al_lo};
        r_sum      = {1'b0, i_reloc_off} + {1'b0, al_lo};
        a_over     = a_sum > {1'b0, i_page_bytes};
        r_over     = r_sum > {1'b0, i_page_bytes};
        total_ext  = CW'(i_page_total);
        full       = total_ext >= CW'(MAX_PAGES);
        reloc_next = CW'(i_reloc_page) + CW'(1);

        o_page_total = i_page_total;
        o_alloc_page = i_alloc_page;
        o_alloc_off  = i_alloc_off;
        o_reloc_page = i_reloc_page;
        o_reloc_off  = i_reloc_off;
        o_compacting = i_compacting;
        dropped      = '0;
        page_wide    = '0;

        o_result        = '0;
        o_result.status = pbacp_pkg::ST_OK;

        case (i_cmd)
            pbacp_pkg::CMD_ALLOC: begin
                if (i_compacting) begin
                    o_result.status = pbacp_pkg::ST_BAD_MODE;
                end else if (33'(i_size) >= 33'(i_large_thr)) begin
                    o_result.is_large = 1'b1;
                end else if (!fits) begin
                    o_result.status = pbacp_pkg::ST_NO_PAGE;
                end else if (i_page_total == '0 || a_over) begin
                    if (full) begin
                        o_result.status = pbacp_pkg::ST_NO_PAGE;
                    end else begin
                        // open a fresh page, object at its start
                        o_alloc_page = i_page_total[PW-1:0];
                        o_alloc_off  = al_lo;
                        o_page_total = i_page_total + TW'(1);
                        page_wide    = 32'(i_page_total[PW-1:0]);
                    end
                end else begin
                    o_alloc_off      = a_sum[pbacp_pkg::OFF_W-1:0];
                    page_wide        = 32'(i_alloc_page);
                    o_result.offset  = i_alloc_off[15:0];
                end
            end
            pbacp_pkg::CMD_BEGIN: begin
                if (i_compacting) begin
                    o_result.status = pbacp_pkg::ST_BAD_MODE;
                end else begin
                    o_compacting = 1'b1;
                    o_reloc_page = '0;
                    o_reloc_off  = '0;
                end
            end
            pbacp_pkg::CMD_PLAN: begin
                if (!i_compacting) begin
                    o_result.status = pbacp_pkg::ST_BAD_MODE;
                end else if (!i_keep) begin
                    o_result.freed = 1'b1;
                end else if (!fits || i_page_total == '0) begin
                    o_result.status = pbacp_pkg::ST_NO_PAGE;
                end else if (r_over) begin
                    if (reloc_next >= total_ext) begin
                        o_result.status = pbacp_pkg::ST_NO_PAGE;
                    end else begin
                        o_reloc_page = reloc_next[PW-1:0];
                        o_reloc_off  = al_lo;
                        page_wide    = 32'(reloc_next[PW-1:0]);
                    end
                end else begin
                    o_reloc_off     = r_sum[pbacp_pkg::OFF_W-1:0];
                    page_wide       = 32'(i_reloc_page);
                    o_result.offset = i_reloc_off[15:0];
                end
            end
            pbacp_pkg::CMD_END: begin
                if (!i_compacting) begin
                    o_result.status = pbacp_pkg::ST_BAD_MODE;
                end else begin
                    o_compacting = 1'b0;
                    if (i_page_total != '0) begin
                        // pages past the last relocation page are released
                        if (reloc_next < total_ext) begin
                            dropped      = i_page_total - reloc_next[TW-1:0];
                            o_page_total = reloc_next[TW-1:0];
                        end
                        o_alloc_page = i_reloc_page;
                        o_alloc_off  = i_reloc_off;
                    end
                end
            end
            default: begin
                o_result.status = pbacp_pkg::ST_BAD_MODE;
            end
        endcase

        total_wide            = 32'(o_page_total);
        drop_wide             = 32'(dropped);
        o_result.page         = page_wide[7:0];
        o_result.pages_in_use = total_wide[8:0];
        o_result.pages_freed  = drop_wide[8:0];
    end

endmodule
